>>> rtl/range_chmax_value_histogram_macros.svh
// Assertion helpers for the file that checks its own logic.
// Each helper samples on clk and is disabled while rst is high.
`ifndef RANGE_CHMAX_VALUE_HISTOGRAM_MACROS_SVH
`define RANGE_CHMAX_VALUE_HISTOGRAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCVH_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rcvh same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCVH_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rcvh next-cycle check failed");

`endif

>>> rtl/rcvh_pkg.sv
package rcvh_pkg;

  // Field and storage widths.
  localparam int LEN_W       = 11;
  localparam int VAL_W       = 12;
  localparam int CNT_W       = 11;
  localparam int FW_W        = 12;
  localparam int STACK_DEPTH = 11;
  localparam int SP_W        = 4;

  // Second minimum of a node that holds a single distinct value.
  localparam logic [VAL_W-1:0] SENTINEL = '1;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [FW_W-1:0]  fw_t;

  // One segment tree node. A fresh node has not been touched since the
  // last clear and stands for its reset values.
  typedef struct packed {
    logic             fresh;
    val_t             min_v;
    val_t             sec_v;
    logic [CNT_W-1:0] cnt;
    val_t             lazy;
  } node_t;

  // Saved segment bounds of an ancestor during the tree walk.
  typedef struct packed {
    len_t l;
    len_t r;
  } frame_t;

  // Datapath commands issued by the controller.
  typedef logic [4:0] cmd_t;
  localparam cmd_t C_NOP       = 5'd0;
  localparam cmd_t C_CLEAR     = 5'd1;
  localparam cmd_t C_LOAD      = 5'd2;
  localparam cmd_t C_QRD       = 5'd3;
  localparam cmd_t C_QACC      = 5'd4;
  localparam cmd_t C_OUT       = 5'd5;
  localparam cmd_t C_NRD_X     = 5'd6;
  localparam cmd_t C_EVAL      = 5'd7;
  localparam cmd_t C_FW0       = 5'd8;
  localparam cmd_t C_FW1       = 5'd9;
  localparam cmd_t C_FWRD      = 5'd10;
  localparam cmd_t C_FWWR      = 5'd11;
  localparam cmd_t C_TAG       = 5'd12;
  localparam cmd_t C_PDRD_A    = 5'd13;
  localparam cmd_t C_PDWR_A    = 5'd14;
  localparam cmd_t C_PDRD_B    = 5'd15;
  localparam cmd_t C_PDWR_B    = 5'd16;
  localparam cmd_t C_PDX       = 5'd17;
  localparam cmd_t C_DESC_L    = 5'd18;
  localparam cmd_t C_DESC_R    = 5'd19;
  localparam cmd_t C_RET_RIGHT = 5'd20;
  localparam cmd_t C_RET_POP   = 5'd21;
  localparam cmd_t C_PURD_A    = 5'd22;
  localparam cmd_t C_PULA      = 5'd23;
  localparam cmd_t C_PULB      = 5'd24;
  localparam cmd_t C_PUWR      = 5'd25;

  // Datapath status used by the controller for its decisions.
  typedef struct packed {
    logic clr_last;
    logic q_in_ok;
    logic qpos_last;
    logic out_free;
    logic x_oob;
    logic min_ge_v;
    logic can_tag;
    logic leaf;
    logic lazy_nz;
    logic fpos_ok;
    logic fphase;
    logic ca_oob;
    logic cb_oob;
    logic go_left;
    logic go_right;
    logic sp_zero;
    logic ret_right;
  } status_t;

  // Replace a fresh node by its reset values for a segment of length len.
  function automatic node_t node_expand(node_t rec, len_t len);
    node_t res;
    res = rec;
    if (rec.fresh) begin
      res.fresh = 1'b0;
      res.min_v = '0;
      res.sec_v = SENTINEL;
      res.cnt   = len;
      res.lazy  = '0;
    end
    return res;
  endfunction

  // Apply a max tag to an expanded node.
  function automatic node_t node_tag(node_t rec, val_t t);
    node_t res;
    res = rec;
    res.fresh = 1'b0;
    if (res.min_v < t) begin
      res.min_v = t;
    end
    if (res.lazy < t) begin
      res.lazy = t;
    end
    return res;
  endfunction

endpackage

>>> rtl/rcvh_ram.sv
module rcvh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/rcvh_ctrl.sv
module rcvh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  input  logic                op,
  input  rcvh_pkg::status_t   st,
  output logic                in_ready,
  output rcvh_pkg::cmd_t      cmd
);

  localparam logic [4:0] ST_CLEAR = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_QRD   = 5'd2;
  localparam logic [4:0] ST_QACC  = 5'd3;
  localparam logic [4:0] ST_QDONE = 5'd4;
  localparam logic [4:0] ST_VISIT = 5'd5;
  localparam logic [4:0] ST_EVAL  = 5'd6;
  localparam logic [4:0] ST_DEC   = 5'd7;
  localparam logic [4:0] ST_FWRD  = 5'd8;
  localparam logic [4:0] ST_FWWR  = 5'd9;
  localparam logic [4:0] ST_TAG   = 5'd10;
  localparam logic [4:0] ST_PDA   = 5'd11;
  localparam logic [4:0] ST_PDAW  = 5'd12;
  localparam logic [4:0] ST_PDB   = 5'd13;
  localparam logic [4:0] ST_PDBW  = 5'd14;
  localparam logic [4:0] ST_PDX   = 5'd15;
  localparam logic [4:0] ST_DESC  = 5'd16;
  localparam logic [4:0] ST_RET   = 5'd17;
  localparam logic [4:0] ST_PU    = 5'd18;
  localparam logic [4:0] ST_PUA   = 5'd19;
  localparam logic [4:0] ST_PUB   = 5'd20;
  localparam logic [4:0] ST_PUW   = 5'd21;

  logic [4:0] state;
  logic [4:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = rcvh_pkg::C_NOP;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd = rcvh_pkg::C_CLEAR;
        if (st.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = rcvh_pkg::C_LOAD;
          if (op) begin
            state_next = st.q_in_ok ? ST_QRD : ST_QDONE;
          end else begin
            state_next = ST_VISIT;
          end
        end
      end
      ST_QRD: begin
        cmd        = rcvh_pkg::C_QRD;
        state_next = ST_QACC;
      end
      ST_QACC: begin
        cmd        = rcvh_pkg::C_QACC;
        state_next = st.qpos_last ? ST_QDONE : ST_QRD;
      end
      ST_QDONE: begin
        if (st.out_free) begin
          cmd        = rcvh_pkg::C_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_VISIT: begin
        if (st.x_oob) begin
          state_next = ST_RET;
        end else begin
          cmd        = rcvh_pkg::C_NRD_X;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd        = rcvh_pkg::C_EVAL;
        state_next = ST_DEC;
      end
      ST_DEC: begin
        if (st.min_ge_v) begin
          state_next = ST_RET;
        end else if (st.can_tag) begin
          cmd        = rcvh_pkg::C_FW0;
          state_next = ST_FWRD;
        end else if (st.leaf) begin
          state_next = ST_RET;
        end else if (st.lazy_nz) begin
          state_next = ST_PDA;
        end else begin
          state_next = ST_DESC;
        end
      end
      ST_FWRD: begin
        if (st.fpos_ok) begin
          cmd        = rcvh_pkg::C_FWRD;
          state_next = ST_FWWR;
        end else if (!st.fphase) begin
          cmd        = rcvh_pkg::C_FW1;
          state_next = ST_FWRD;
        end else begin
          state_next = ST_TAG;
        end
      end
      ST_FWWR: begin
        cmd        = rcvh_pkg::C_FWWR;
        state_next = ST_FWRD;
      end
      ST_TAG: begin
        cmd        = rcvh_pkg::C_TAG;
        state_next = ST_RET;
      end
      ST_PDA: begin
        if (st.ca_oob) begin
          state_next = ST_PDB;
        end else begin
          cmd        = rcvh_pkg::C_PDRD_A;
          state_next = ST_PDAW;
        end
      end
      ST_PDAW: begin
        cmd        = rcvh_pkg::C_PDWR_A;
        state_next = ST_PDB;
      end
      ST_PDB: begin
        if (st.cb_oob) begin
          state_next = ST_PDX;
        end else begin
          cmd        = rcvh_pkg::C_PDRD_B;
          state_next = ST_PDBW;
        end
      end
      ST_PDBW: begin
        cmd        = rcvh_pkg::C_PDWR_B;
        state_next = ST_PDX;
      end
      ST_PDX: begin
        cmd        = rcvh_pkg::C_PDX;
        state_next = ST_DESC;
      end
      ST_DESC: begin
        if (st.go_left) begin
          cmd        = rcvh_pkg::C_DESC_L;
          state_next = ST_VISIT;
        end else if (st.go_right) begin
          cmd        = rcvh_pkg::C_DESC_R;
          state_next = ST_VISIT;
        end else begin
          state_next = ST_PU;
        end
      end
      ST_RET: begin
        if (st.sp_zero) begin
          state_next = ST_IDLE;
        end else if (st.ret_right) begin
          cmd        = rcvh_pkg::C_RET_RIGHT;
          state_next = ST_VISIT;
        end else begin
          cmd        = rcvh_pkg::C_RET_POP;
          state_next = ST_PU;
        end
      end
      ST_PU: begin
        if (st.cb_oob) begin
          state_next = ST_RET;
        end else begin
          cmd        = rcvh_pkg::C_PURD_A;
          state_next = ST_PUA;
        end
      end
      ST_PUA: begin
        cmd        = rcvh_pkg::C_PULA;
        state_next = ST_PUB;
      end
      ST_PUB: begin
        cmd        = rcvh_pkg::C_PULB;
        state_next = ST_PUW;
      end
      ST_PUW: begin
        cmd        = rcvh_pkg::C_PUWR;
        state_next = ST_RET;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // A length write restarts the clearing sweep.
    if (cfg_we) begin
      state_next = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/rcvh_dp.sv
module rcvh_dp #(
  parameter int MAX_LENGTH = 1024,
  parameter int TREE_NODES = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rcvh_pkg::LEN_W-1:0]    cfg_data,
  input  logic [rcvh_pkg::LEN_W-1:0]    range_low,
  input  logic [rcvh_pkg::LEN_W-1:0]    range_high,
  input  logic [rcvh_pkg::LEN_W-1:0]    raise_value,
  input  logic [rcvh_pkg::LEN_W-1:0]    query_pos,
  input  logic                          out_ready,
  input  rcvh_pkg::cmd_t                cmd,
  output rcvh_pkg::status_t             st,
  output logic                          out_valid,
  output logic [rcvh_pkg::LEN_W-1:0]    count_at_least
);

  localparam int NODE_AW   = $clog2(TREE_NODES);
  localparam int X_W       = NODE_AW + 1;
  localparam int FW_AW     = $clog2(MAX_LENGTH);
  localparam int CLEAR_LEN = (TREE_NODES > MAX_LENGTH) ? TREE_NODES : MAX_LENGTH;
  localparam int CLR_W     = $clog2(CLEAR_LEN);
  localparam int LEN_RESET = (MAX_LENGTH > 2047) ? 2047 : MAX_LENGTH;
  localparam int NODE_BITS = $bits(rcvh_pkg::node_t);

  localparam rcvh_pkg::len_t  LEN_MAX  = rcvh_pkg::LEN_W'(LEN_RESET);
  localparam logic [X_W:0]    TN_X     = (X_W + 1)'(TREE_NODES);
  localparam logic [CLR_W:0]  TN_CLR   = (CLR_W + 1)'(TREE_NODES);
  localparam logic [CLR_W:0]  ML_CLR   = (CLR_W + 1)'(MAX_LENGTH);
  localparam logic [CLR_W-1:0] CLR_END = CLR_W'(CLEAR_LEN - 1);

  // Control registers.
  rcvh_pkg::len_t             used_len;
  logic [CLR_W-1:0]           clr_idx;
  logic [rcvh_pkg::SP_W-1:0]  sp;

  // Transaction and walk registers.
  rcvh_pkg::len_t   lo;
  rcvh_pkg::len_t   hi;
  rcvh_pkg::len_t   v;
  rcvh_pkg::len_t   qpos;
  rcvh_pkg::fw_t    sum;
  logic [X_W-1:0]   x;
  rcvh_pkg::len_t   l;
  rcvh_pkg::len_t   r;
  rcvh_pkg::node_t  cur;
  rcvh_pkg::node_t  ra;
  rcvh_pkg::node_t  rb;
  rcvh_pkg::fw_t    fpos;
  rcvh_pkg::fw_t    delta;
  logic             fphase;
  rcvh_pkg::frame_t stack [rcvh_pkg::STACK_DEPTH];

  // Memory ports.
  logic                  n_we;
  logic [NODE_AW-1:0]    n_addr;
  rcvh_pkg::node_t       n_wdata;
  logic [NODE_BITS-1:0]  n_rdata;
  rcvh_pkg::node_t       n_rd;
  logic                  f_we;
  logic [FW_AW-1:0]      f_addr;
  rcvh_pkg::fw_t         f_wdata;
  rcvh_pkg::fw_t         f_rdata;

  // Derived values.
  rcvh_pkg::len_t             mid;
  rcvh_pkg::len_t             len_self;
  rcvh_pkg::len_t             len_left;
  rcvh_pkg::len_t             len_right;
  logic [rcvh_pkg::SP_W-1:0]  sp_m1;
  rcvh_pkg::frame_t           top;
  rcvh_pkg::len_t             tmid;
  logic [X_W:0]               x_ext;
  logic [X_W:0]               x2;
  logic [X_W:0]               x2p1;
  rcvh_pkg::val_t             v_ext;
  rcvh_pkg::fw_t              f_low;
  rcvh_pkg::len_t             q_low;
  rcvh_pkg::node_t            pull_rec;
  rcvh_pkg::val_t             pm;
  rcvh_pkg::val_t             psa;
  rcvh_pkg::val_t             psb;
  rcvh_pkg::node_t            fresh_rec;

  assign n_rd = rcvh_pkg::node_t'(n_rdata);

  // Segment arithmetic of the current node and of the parent on the stack.
  always_comb begin
    mid       = rcvh_pkg::LEN_W'(({1'b0, l} + {1'b0, r}) >> 1);
    len_self  = r - l + rcvh_pkg::LEN_W'(1);
    len_left  = mid - l + rcvh_pkg::LEN_W'(1);
    len_right = r - mid;
    sp_m1     = sp - rcvh_pkg::SP_W'(1);
    top       = stack[sp_m1];
    tmid      = rcvh_pkg::LEN_W'(({1'b0, top.l} + {1'b0, top.r}) >> 1);
    x_ext     = {1'b0, x};
    x2        = {x, 1'b0};
    x2p1      = {x, 1'b1};
    v_ext     = rcvh_pkg::VAL_W'(v);
    f_low     = fpos & (~fpos + rcvh_pkg::FW_W'(1));
    q_low     = qpos & (~qpos + rcvh_pkg::LEN_W'(1));
  end

  // Merge of the two children into their parent.
  always_comb begin
    pm  = (ra.min_v < rb.min_v) ? ra.min_v : rb.min_v;
    psa = (ra.min_v == pm) ? ra.sec_v : ra.min_v;
    psb = (rb.min_v == pm) ? rb.sec_v : rb.min_v;
    pull_rec.fresh = 1'b0;
    pull_rec.min_v = pm;
    pull_rec.sec_v = (psa < psb) ? psa : psb;
    pull_rec.cnt   = ((ra.min_v == pm) ? ra.cnt : '0) + ((rb.min_v == pm) ? rb.cnt : '0);
    pull_rec.lazy  = '0;
    fresh_rec       = '0;
    fresh_rec.fresh = 1'b1;
  end

  // Status toward the controller.
  always_comb begin
    st.clr_last  = (clr_idx == CLR_END);
    st.q_in_ok   = (query_pos != '0) && (query_pos <= used_len);
    st.qpos_last = (qpos == q_low);
    st.out_free  = !out_valid || out_ready;
    st.x_oob     = (x_ext >= TN_X);
    st.min_ge_v  = (cur.min_v >= v_ext);
    st.can_tag   = (lo <= l) && (r <= hi) && (cur.sec_v > v_ext);
    st.leaf      = (l == r);
    st.lazy_nz   = (cur.lazy != '0);
    st.fpos_ok   = (fpos != '0) && (fpos <= rcvh_pkg::FW_W'(used_len));
    st.fphase    = fphase;
    st.ca_oob    = (x2 >= TN_X);
    st.cb_oob    = (x2p1 >= TN_X);
    st.go_left   = (lo <= mid);
    st.go_right  = (hi > mid);
    st.sp_zero   = (sp == '0);
    st.ret_right = !x[0] && (hi > tmid);
  end

  // Node memory port selection.
  always_comb begin
    n_we    = 1'b0;
    n_addr  = NODE_AW'(x);
    n_wdata = cur;
    case (cmd)
      rcvh_pkg::C_CLEAR: begin
        n_we    = ({1'b0, clr_idx} < TN_CLR);
        n_addr  = NODE_AW'(clr_idx);
        n_wdata = fresh_rec;
      end
      rcvh_pkg::C_PDRD_A, rcvh_pkg::C_PURD_A: begin
        n_addr = NODE_AW'(x2);
      end
      rcvh_pkg::C_PDWR_A: begin
        n_we    = 1'b1;
        n_addr  = NODE_AW'(x2);
        n_wdata = rcvh_pkg::node_tag(rcvh_pkg::node_expand(n_rd, len_left), cur.lazy);
      end
      rcvh_pkg::C_PDRD_B, rcvh_pkg::C_PULA: begin
        n_addr = NODE_AW'(x2p1);
      end
      rcvh_pkg::C_PDWR_B: begin
        n_we    = 1'b1;
        n_addr  = NODE_AW'(x2p1);
        n_wdata = rcvh_pkg::node_tag(rcvh_pkg::node_expand(n_rd, len_right), cur.lazy);
      end
      rcvh_pkg::C_PDX: begin
        n_we         = 1'b1;
        n_wdata.lazy = '0;
      end
      rcvh_pkg::C_TAG: begin
        n_we    = 1'b1;
        n_wdata = rcvh_pkg::node_tag(cur, v_ext);
      end
      rcvh_pkg::C_PUWR: begin
        n_we    = 1'b1;
        n_wdata = pull_rec;
      end
      default: begin
        n_we = 1'b0;
      end
    endcase
  end

  // Fenwick memory port selection.
  always_comb begin
    f_we    = 1'b0;
    f_addr  = FW_AW'(fpos - rcvh_pkg::FW_W'(1));
    f_wdata = f_rdata + delta;
    case (cmd)
      rcvh_pkg::C_CLEAR: begin
        f_we    = ({1'b0, clr_idx} < ML_CLR);
        f_addr  = FW_AW'(clr_idx);
        f_wdata = '0;
      end
      rcvh_pkg::C_QRD: begin
        f_addr = FW_AW'(qpos - rcvh_pkg::LEN_W'(1));
      end
      rcvh_pkg::C_FWWR: begin
        f_we = 1'b1;
      end
      default: begin
        f_we = 1'b0;
      end
    endcase
  end

  rcvh_ram #(.WIDTH(NODE_BITS), .DEPTH(TREE_NODES)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .addr  (n_addr),
    .wdata (n_wdata),
    .rdata (n_rdata)
  );

  rcvh_ram #(.WIDTH(rcvh_pkg::FW_W), .DEPTH(MAX_LENGTH)) u_fw_ram (
    .clk   (clk),
    .we    (f_we),
    .addr  (f_addr),
    .wdata (f_wdata),
    .rdata (f_rdata)
  );

  // Control state: length register, sweep index, stack pointer, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_len  <= LEN_MAX;
      clr_idx   <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        rcvh_pkg::C_CLEAR: begin
          clr_idx <= clr_idx + CLR_W'(1);
          sp      <= '0;
        end
        rcvh_pkg::C_LOAD: begin
          sp <= '0;
        end
        rcvh_pkg::C_OUT: begin
          out_valid <= 1'b1;
        end
        rcvh_pkg::C_DESC_L, rcvh_pkg::C_DESC_R: begin
          sp <= sp + rcvh_pkg::SP_W'(1);
        end
        rcvh_pkg::C_RET_POP: begin
          sp <= sp_m1;
        end
        default: begin
          sp <= sp;
        end
      endcase
      // The length is clamped to the supported range.
      if (cfg_we) begin
        clr_idx <= '0;
        if (cfg_data == '0) begin
          used_len <= rcvh_pkg::LEN_W'(1);
        end else if (cfg_data > LEN_MAX) begin
          used_len <= LEN_MAX;
        end else begin
          used_len <= cfg_data;
        end
      end
    end
  end

  // Transaction and walk registers.
  always_ff @(posedge clk) begin
    case (cmd)
      rcvh_pkg::C_LOAD: begin
        lo   <= range_low;
        hi   <= range_high;
        v    <= raise_value;
        qpos <= query_pos;
        sum  <= '0;
        x    <= X_W'(1);
        l    <= rcvh_pkg::LEN_W'(1);
        r    <= used_len;
      end
      rcvh_pkg::C_QACC: begin
        sum  <= sum + f_rdata;
        qpos <= qpos - q_low;
      end
      rcvh_pkg::C_OUT: begin
        count_at_least <= sum[rcvh_pkg::LEN_W-1:0];
      end
      rcvh_pkg::C_EVAL: begin
        cur <= rcvh_pkg::node_expand(n_rd, len_self);
      end
      rcvh_pkg::C_FW0: begin
        fpos   <= cur.min_v + rcvh_pkg::FW_W'(1);
        delta  <= rcvh_pkg::FW_W'(cur.cnt);
        fphase <= 1'b0;
      end
      rcvh_pkg::C_FW1: begin
        fpos   <= v_ext + rcvh_pkg::FW_W'(1);
        delta  <= '0 - rcvh_pkg::FW_W'(cur.cnt);
        fphase <= 1'b1;
      end
      rcvh_pkg::C_FWWR: begin
        fpos <= fpos + f_low;
      end
      rcvh_pkg::C_DESC_L: begin
        stack[sp] <= '{l: l, r: r};
        x         <= X_W'(x2);
        r         <= mid;
      end
      rcvh_pkg::C_DESC_R: begin
        stack[sp] <= '{l: l, r: r};
        x         <= X_W'(x2p1);
        l         <= mid + rcvh_pkg::LEN_W'(1);
      end
      rcvh_pkg::C_RET_RIGHT: begin
        x <= x + X_W'(1);
        l <= tmid + rcvh_pkg::LEN_W'(1);
        r <= top.r;
      end
      rcvh_pkg::C_RET_POP: begin
        x <= x >> 1;
        l <= top.l;
        r <= top.r;
      end
      rcvh_pkg::C_PULA: begin
        ra <= rcvh_pkg::node_expand(n_rd, len_left);
      end
      rcvh_pkg::C_PULB: begin
        rb <= rcvh_pkg::node_expand(n_rd, len_right);
      end
      default: begin
        sum <= sum;
      end
    endcase
  end

endmodule

>>> rtl/range_chmax_value_histogram.sv
// Range chmax with a value histogram.
// Input channel (in_valid/in_ready) carries one transaction: op 0 raises every
// position in range_low..range_high to at least raise_value, op 1 asks how
// many positions hold a value of at least query_pos. Only queries produce an
// output transaction (out_valid/out_ready) carrying count_at_least.
// cfg_we/cfg_data write the number of positions in use and rebuild all state.
// One transaction is worked on at a time. A query reads and adds up each
// Fenwick node on its chain (at most 11). An update visits tree nodes, walks
// the Fenwick memory for each raise, and pushes down and merges nodes on
// its way. The single-port node memory and Fenwick memory serialise these
// steps. After reset or a length write the block sweeps both memories over
// max(TREE_NODES, MAX_LENGTH) addresses (2048 by default) with in_ready low.
// A finished result waits in the output register; while it stalls, the next
// transaction is still taken and only a second query result waits for it.
`include "range_chmax_value_histogram_macros.svh"

module range_chmax_value_histogram #(
  parameter int MAX_LENGTH = 1024,
  parameter int TREE_NODES = 2048
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rcvh_pkg::LEN_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [rcvh_pkg::LEN_W-1:0]  range_low,
  input  logic [rcvh_pkg::LEN_W-1:0]  range_high,
  input  logic [rcvh_pkg::LEN_W-1:0]  raise_value,
  input  logic [rcvh_pkg::LEN_W-1:0]  query_pos,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcvh_pkg::LEN_W-1:0]  count_at_least
);

  rcvh_pkg::status_t st;
  rcvh_pkg::cmd_t    cmd;

  rcvh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .op       (op),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  rcvh_dp #(.MAX_LENGTH(MAX_LENGTH), .TREE_NODES(TREE_NODES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .range_low      (range_low),
    .range_high     (range_high),
    .raise_value    (raise_value),
    .query_pos      (query_pos),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .count_at_least (count_at_least)
  );

  // An accepted transaction keeps the block busy in the cycle after it is taken.
  `RCVH_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
  // The walk stack is empty whenever a new transaction can be taken.
  `RCVH_ASSERT_IMP(a_idle_stack_empty, in_ready, st.sp_zero)
  // Nothing touches the datapath while idle with no transaction offered.
  `RCVH_ASSERT_IMP(a_idle_quiet, in_ready && !in_valid, cmd == rcvh_pkg::C_NOP)
  // A result is only loaded when the output register is free.
  `RCVH_ASSERT_IMP(a_out_load_free, cmd == rcvh_pkg::C_OUT, st.out_free)

endmodule

>>> bench/histogram_checker.sv
// Watches the channels of the range chmax block, keeps its own copy of the
// position values and checks every count that the block returns.
module histogram_checker #(
  parameter int MAX_LENGTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rcvh_pkg::LEN_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       op,
  input  logic [rcvh_pkg::LEN_W-1:0] range_low,
  input  logic [rcvh_pkg::LEN_W-1:0] range_high,
  input  logic [rcvh_pkg::LEN_W-1:0] raise_value,
  input  logic [rcvh_pkg::LEN_W-1:0] query_pos,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [rcvh_pkg::LEN_W-1:0] count_at_least,
  output int                         fail_count,
  output int                         counts_pending
);
  import rcvh_pkg::*;

  localparam logic OP_CHMAX = 1'b0;

  len_t level [1:MAX_LENGTH];
  int   active_length;
  len_t expected_counts [$];

  assign counts_pending = expected_counts.size();

  // Restores all positions to zero and sets the given length.
  function automatic void clear_levels(int len);
    for (int i = 1; i <= MAX_LENGTH; i++) begin
      level[i] = '0;
    end
    active_length = len;
  endfunction

  // Raises every position of the clipped range to at least the value.
  function automatic void apply_chmax(len_t lo, len_t hi, len_t v);
    int first;
    int last;
    first = (lo < 1) ? 1 : int'(lo);
    last  = (hi > active_length) ? active_length : int'(hi);
    for (int i = first; i <= last; i++) begin
      if (level[i] < v) begin
        level[i] = v;
      end
    end
  endfunction

  // Counts the positions whose value reaches the threshold; a zero or out-of-length threshold gives zero.
  function automatic len_t count_reaching(len_t q);
    int n;
    n = 0;
    if (q == 0 || q > active_length) begin
      return '0;
    end
    for (int i = 1; i <= active_length; i++) begin
      if (level[i] >= q) begin
        n++;
      end
    end
    return len_t'(n);
  endfunction

  initial begin
    fail_count = 0;
    clear_levels(MAX_LENGTH);
  end

  // Follow each accepted transaction and compare each delivered count.
  always @(posedge clk) begin
    int len;
    len_t want;
    if (rst) begin
      clear_levels(MAX_LENGTH);
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        len = int'(cfg_data);
        if (len < 1) len = 1;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        clear_levels(len);
      end
      if (in_valid && in_ready) begin
        if (op == OP_CHMAX) begin
          apply_chmax(range_low, range_high, raise_value);
        end else begin
          expected_counts.push_back(count_reaching(query_pos));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("count_at_least: unexpected result %0d", count_at_least);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (count_at_least !== want) begin
            $error("count_at_least: expected %0d, actual %0d", want, count_at_least);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> bench/tb_top.sv
// Drives the range chmax block with directed and random transactions over
// several lengths, with bursty input and a stalling output side.
module tb_top;
  import rcvh_pkg::*;

  localparam logic OP_CHMAX = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int   CFG_LENGTH = 0;
  localparam int   SETTLE_CYCLES = 6000;
  localparam int   CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  logic cfg_we;
  len_t cfg_data;
  logic in_valid;
  logic in_ready;
  logic op;
  len_t range_low;
  len_t range_high;
  len_t raise_value;
  len_t query_pos;
  logic out_valid;
  logic out_ready;
  len_t count_at_least;
  int   fail_count;
  int   counts_pending;
  int   cycle_count;
  int   burst_left;
  int   cur_length;

  range_chmax_value_histogram u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .range_low(range_low), .range_high(range_high),
    .raise_value(raise_value), .query_pos(query_pos),
    .out_valid(out_valid), .out_ready(out_ready),
    .count_at_least(count_at_least)
  );

  histogram_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .range_low(range_low), .range_high(range_high),
    .raise_value(raise_value), .query_pos(query_pos),
    .out_valid(out_valid), .out_ready(out_ready),
    .count_at_least(count_at_least),
    .fail_count(fail_count), .counts_pending(counts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver switches between stall patterns of its own.
  always @(posedge clk) begin
    int stall_mode;
    if (($urandom % 64) == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom % 2) == 0;
      2: out_ready <= ($urandom % 8) == 0;
      default: out_ready <= ($urandom % 4) != 0;
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Sends one transaction; valid stays high inside a burst.
  task automatic send_item(logic o, len_t lo, len_t hi, len_t v, len_t q);
    op          <= o;
    range_low   <= lo;
    range_high  <= hi;
    raise_value <= v;
    query_pos   <= q;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom % 4 == 0) ? 1000 : $urandom_range(1, 20);
    end
  endtask

  // Waits for every pending count, lets a trailing update finish, then
  // writes a new length.
  task automatic set_length(len_t len);
    in_valid <= 1'b0;
    @(posedge clk);
    while (counts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_length = (len < 1) ? 1 : ((len > 1024) ? 1024 : int'(len));
  endtask

  // Random transactions, mostly well formed within the current length.
  task automatic random_items(int n);
    len_t lo;
    len_t hi;
    len_t v;
    len_t q;
    len_t t;
    for (int i = 0; i < n; i++) begin
      lo = len_t'($urandom_range(1, cur_length));
      hi = len_t'($urandom_range(1, cur_length));
      if (lo > hi && ($urandom % 4) != 0) begin
        t = lo; lo = hi; hi = t;
      end
      v = len_t'($urandom_range(1, cur_length + 1));
      q = len_t'($urandom_range(1, cur_length));
      if (($urandom % 10) == 0) begin
        lo = len_t'($urandom);
        hi = len_t'($urandom);
        v  = len_t'($urandom);
        q  = len_t'($urandom);
      end
      send_item(($urandom % 2) ? OP_QUERY : OP_CHMAX, lo, hi, v, q);
      if (i == n / 2) begin
        // Hold off until every count of this phase has come back.
        in_valid <= 1'b0;
        @(posedge clk);
        while (counts_pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    op          = OP_CHMAX;
    range_low   = '0;
    range_high  = '0;
    raise_value = '0;
    query_pos   = '0;
    out_ready   = 1'b0;
    cycle_count = 0;
    burst_left  = 5;
    cur_length  = 1024;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset length.
    send_item(OP_QUERY, 0, 0, 0, 1);
    send_item(OP_CHMAX, 1, 1024, 1, 0);
    send_item(OP_QUERY, 0, 0, 0, 1);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_CHMAX, 0, 2047, 5, 0);
    send_item(OP_CHMAX, 10, 3, 900, 0);
    send_item(OP_CHMAX, 1, 1024, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 5);
    send_item(OP_QUERY, 0, 0, 0, 6);
    send_item(OP_CHMAX, 1024, 1024, 1024, 0);
    send_item(OP_QUERY, 0, 0, 0, 1024);
    send_item(OP_QUERY, 0, 0, 0, 1025);
    send_item(OP_QUERY, 0, 0, 0, 2047);
    send_item(OP_CHMAX, 300, 700, 2047, 0);
    send_item(OP_CHMAX, 200, 400, 600, 0);
    send_item(OP_QUERY, 0, 0, 0, 600);
    send_item(OP_QUERY, 0, 0, 0, 601);
    send_item(OP_CHMAX, 1, 1, 1023, 0);
    send_item(OP_QUERY, 0, 0, 0, 1023);
    send_item(OP_CHMAX, 1025, 2047, 50, 0);
    send_item(OP_QUERY, 0, 0, 0, 50);
    random_items(500);

    set_length(1);
    random_items(150);
    set_length(7);
    random_items(250);
    set_length(2047);
    random_items(350);
    set_length(0);
    random_items(100);
    set_length(len_t'($urandom_range(2, 1024)));
    random_items(300);
    set_length(1024);
    random_items(280);

    in_valid <= 1'b0;
    @(posedge clk);
    while (counts_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && counts_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

>>> range_chmax_value_histogram.f
+incdir+rtl
rtl/rcvh_pkg.sv
rtl/rcvh_ram.sv
rtl/rcvh_ctrl.sv
rtl/rcvh_dp.sv
rtl/range_chmax_value_histogram.sv
bench/histogram_checker.sv
bench/tb_top.sv
